// ===== sv/sslms_pkg.sv =====
// shared types, constants and helpers for the sign-sign lms predictor
// used by sslms_cell, sslms_mac and sign_sign_lms_predictor; no dependencies
`default_nettype none

package sslms_pkg;

   localparam int MAX_TAPS_DEF = 32;
   localparam int SAMPLE_W     = 24;
   localparam int WEIGHT_W     = 32;
   localparam int RESIDUAL_W   = 32;
   localparam int PRED_W       = 32;
   localparam int TAP_COUNT_W  = 6;
   localparam int CSR_DATA_W   = 6;
   localparam int CSR_INDEX_W  = 1;
   localparam int SHIFT_W      = 4;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 6'd32;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_SAMPLES = 1'd1;

   // product shift for 16-bit and 24-bit pcm
   localparam logic [SHIFT_W-1:0] SHIFT_BY_WIDTH [2] = '{4'd9, 4'd8};

   // two-bit sign code: zero, plus one, minus one
   typedef logic [1:0] sign_type;
   localparam sign_type SIGN_ZERO = 2'b00;
   localparam sign_type SIGN_POS  = 2'b01;
   localparam sign_type SIGN_NEG  = 2'b11;

   // per-cycle commands broadcast to every cell of the row
   typedef struct packed {
      logic     shift_en;   // weight update plus delay line shift
      logic     rotate_en;  // rotate the row one place toward cell 0
      sign_type res_sign;   // sign of the residual being applied
   } cell_ctrl_type;

   function automatic sign_type sample_sign(input logic [SAMPLE_W-1:0] value);
      sign_type result;
      if (value == '0) begin
         result = SIGN_ZERO;
      end else if (value[SAMPLE_W-1]) begin
         result = SIGN_NEG;
      end else begin
         result = SIGN_POS;
      end
      return result;
   endfunction

   function automatic sign_type residual_sign(input logic [RESIDUAL_W-1:0] value);
      sign_type result;
      if (value == '0) begin
         result = SIGN_ZERO;
      end else if (value[RESIDUAL_W-1]) begin
         result = SIGN_NEG;
      end else begin
         result = SIGN_POS;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sslms_cell.sv =====
// one tap of the predictor: weight, delayed sample and its sign
// depends on sslms_pkg
`default_nettype none

module sslms_cell (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire sslms_pkg::cell_ctrl_type         ctrl,
   input  wire                                   tap_on,
   // from the lower neighbor (or the new sample at cell 0)
   input  wire logic [sslms_pkg::SAMPLE_W-1:0]   shift_sample,
   input  wire sslms_pkg::sign_type              shift_sign,
   // from the upper neighbor during rotation
   input  wire logic [sslms_pkg::WEIGHT_W-1:0]   rot_weight,
   input  wire logic [sslms_pkg::SAMPLE_W-1:0]   rot_sample,
   input  wire sslms_pkg::sign_type              rot_sign,
   output logic      [sslms_pkg::WEIGHT_W-1:0]   weight,
   output logic      [sslms_pkg::SAMPLE_W-1:0]   sample,
   output sslms_pkg::sign_type                   sign
);

   logic [sslms_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [sslms_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   sslms_pkg::sign_type            sign_ff, sign_in;
   logic                           step_up, step_down;

   // sign(residual) * sign(history), old sign before the shift
   assign step_up   = tap_on &&
                      ((ctrl.res_sign == sslms_pkg::SIGN_POS && sign_ff == sslms_pkg::SIGN_POS) ||
                       (ctrl.res_sign == sslms_pkg::SIGN_NEG && sign_ff == sslms_pkg::SIGN_NEG));
   assign step_down = tap_on &&
                      ((ctrl.res_sign == sslms_pkg::SIGN_POS && sign_ff == sslms_pkg::SIGN_NEG) ||
                       (ctrl.res_sign == sslms_pkg::SIGN_NEG && sign_ff == sslms_pkg::SIGN_POS));

   always_comb begin
      weight_in = weight_ff;
      sample_in = sample_ff;
      sign_in   = sign_ff;
      if (ctrl.shift_en) begin
         if (step_up) begin
            weight_in = weight_ff + 32'd1;
         end else if (step_down) begin
            weight_in = weight_ff - 32'd1;
         end
         sample_in = shift_sample;
         sign_in   = shift_sign;
      end else if (ctrl.rotate_en) begin
         weight_in = rot_weight;
         sample_in = rot_sample;
         sign_in   = rot_sign;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
         sample_ff <= '0;
         sign_ff   <= sslms_pkg::SIGN_ZERO;
      end else begin
         weight_ff <= weight_in;
         sample_ff <= sample_in;
         sign_ff   <= sign_in;
      end
   end

   assign weight = weight_ff;
   assign sample = sample_ff;
   assign sign   = sign_ff;

endmodule

`default_nettype wire

// ===== sv/sslms_mac.sv =====
// multiply-accumulate unit: registered product, shifted and summed
// depends on sslms_pkg
`default_nettype none

module sslms_mac (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 clear,
   input  wire                                 capture,
   input  wire                                 wide_samples,
   input  wire logic [sslms_pkg::WEIGHT_W-1:0] weight,
   input  wire logic [sslms_pkg::SAMPLE_W-1:0] sample,
   output logic      [sslms_pkg::PRED_W-1:0]   sum
);

   localparam int FULL_W = sslms_pkg::WEIGHT_W + sslms_pkg::SAMPLE_W;

   logic signed [FULL_W-1:0]             full_product;
   logic        [sslms_pkg::PRED_W-1:0]  prod_ff, prod_in;
   logic                                 prod_vld_ff, prod_vld_in;
   logic        [sslms_pkg::PRED_W-1:0]  acc_ff, acc_in;
   logic        [sslms_pkg::PRED_W-1:0]  shifted;
   logic        [sslms_pkg::SHIFT_W-1:0] shift_amt;

   assign full_product = FULL_W'($signed(weight)) * FULL_W'($signed(sample));
   assign prod_in      = full_product[sslms_pkg::PRED_W-1:0];   // wraps at 32 bits
   assign prod_vld_in  = capture && !clear;
   assign shift_amt    = sslms_pkg::SHIFT_BY_WIDTH[wide_samples];
   assign shifted      = $unsigned($signed(prod_ff) >>> shift_amt);

   always_comb begin
      if (clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + shifted;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sum = acc_ff;

endmodule

`default_nettype wire

// ===== sv/sign_sign_lms_predictor.sv =====
// input: a new item is accepted only in idle (req_stall is high otherwise), as the single multiplier
//   walks the tap row one place per cycle
// reset: synchronous, clears weights, delay lines and signs, tap_count=32, 16-bit pcm
// depends on sslms_pkg, sslms_cell, sslms_mac
`default_nettype none

module sign_sign_lms_predictor #(
   parameter int MAX_TAPS = sslms_pkg::MAX_TAPS_DEF
) (
   input  wire                                      clock,
   input  wire                                      reset,
   // configuration port
   input  wire                                      csr_wr_en,
   input  wire logic [sslms_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sslms_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // input channel
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire logic signed [sslms_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  wire logic signed [sslms_pkg::RESIDUAL_W-1:0] req_residual_value,
   // result channel
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic signed [sslms_pkg::PRED_W-1:0]      rsp_next_prediction
);

   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam logic [IDX_W-1:0] LAST_TAP = IDX_W'(MAX_TAPS - 1);

   // one-hot sequencer
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,   // waiting for an input transfer
      ST_ACCUM  = 4'b0010,   // rotating the row through the multiplier
      ST_LAST   = 4'b0100,   // folding in the final product
      ST_FINISH = 4'b1000    // handing the sum to the output register
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] tap_cnt_ff, tap_cnt_in;

   // configuration registers
   logic [sslms_pkg::TAP_COUNT_W-1:0] tap_count_ff, tap_count_in;
   logic                              wide_ff, wide_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sslms_pkg::PRED_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                     req_xfer, rsp_free;
   sslms_pkg::cell_ctrl_type cell_ctrl;
   sslms_pkg::sign_type      new_sign;
   logic                     mac_clear, mac_capture;
   logic [sslms_pkg::PRED_W-1:0] mac_sum;

   logic [sslms_pkg::WEIGHT_W-1:0] cell_weight [MAX_TAPS];
   logic [sslms_pkg::SAMPLE_W-1:0] cell_sample [MAX_TAPS];
   sslms_pkg::sign_type            cell_sign   [MAX_TAPS];
   logic [MAX_TAPS-1:0]            tap_on;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign new_sign  = sslms_pkg::sample_sign(req_sample_value);

   // configuration writes
   always_comb begin
      tap_count_in = tap_count_ff;
      wide_in      = wide_ff;
      if (csr_wr_en) begin
         case (csr_index)
            sslms_pkg::CSR_TAP_COUNT:    tap_count_in = csr_wdata;
            sslms_pkg::CSR_WIDE_SAMPLES: wide_in      = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // sequencer: update and shift on the input transfer, then MAX_TAPS rotations that
   // bring every tap past cell 0 and leave the row where it started
   always_comb begin
      state_in   = state_ff;
      tap_cnt_in = tap_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            tap_cnt_in = '0;
            if (req_xfer) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (tap_cnt_ff == LAST_TAP) begin
               tap_cnt_in = '0;
               state_in   = ST_LAST;
            end else begin
               tap_cnt_in = tap_cnt_ff + IDX_W'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in   = ST_IDLE;
            tap_cnt_in = '0;
         end
      endcase
   end

   assign cell_ctrl.shift_en  = req_xfer;
   assign cell_ctrl.rotate_en = (state_ff == ST_ACCUM);
   assign cell_ctrl.res_sign  = sslms_pkg::residual_sign(req_residual_value);

   // tap counts above MAX_TAPS saturate naturally: every index is below it
   assign mac_clear   = req_xfer;
   assign mac_capture = (state_ff == ST_ACCUM) &&
                        (32'(tap_cnt_ff) < 32'(tap_count_ff));

   // output register takes the sum once the slot is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = mac_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_cnt_ff   <= '0;
         tap_count_ff <= sslms_pkg::TAP_COUNT_RESET;
         wide_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_cnt_ff   <= tap_cnt_in;
         tap_count_ff <= tap_count_in;
         wide_ff      <= wide_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // the tap row: delay line shifts upward, rotation moves toward cell 0
   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_tap
      localparam int UP = (i + 1) % MAX_TAPS;

      logic [sslms_pkg::SAMPLE_W-1:0] shift_sample;
      sslms_pkg::sign_type            shift_sign;

      if (i == 0) begin : g_head
         assign shift_sample = req_sample_value;
         assign shift_sign   = new_sign;
      end else begin : g_body
         assign shift_sample = cell_sample[i-1];
         assign shift_sign   = cell_sign[i-1];
      end

      // weight update only for active taps
      assign tap_on[i] = (32'(i) < 32'(tap_count_ff));

      sslms_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .tap_on       (tap_on[i]),
         .shift_sample (shift_sample),
         .shift_sign   (shift_sign),
         .rot_weight   (cell_weight[UP]),
         .rot_sample   (cell_sample[UP]),
         .rot_sign     (cell_sign[UP]),
         .weight       (cell_weight[i]),
         .sample       (cell_sample[i]),
         .sign         (cell_sign[i])
      );
   end

   // single multiplier watches cell 0
   sslms_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .clear        (mac_clear),
      .capture      (mac_capture),
      .wide_samples (wide_ff),
      .weight       (cell_weight[0]),
      .sample       (cell_sample[0]),
      .sum          (mac_sum)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_prediction = $signed(rsp_data_ff);

   // an input transfer always starts the rotation pass
   a_start_accum: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_ACCUM)
      else $error("transfer did not start accumulation");

   // the pass ends when the tap counter reaches the last tap, after MAX_TAPS rotations
   a_pass_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && tap_cnt_ff == LAST_TAP) |=> state_ff == ST_LAST)
      else $error("rotation pass length wrong");

   // tap counter is parked at zero between items
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FINISH) |-> tap_cnt_ff == '0)
      else $error("tap counter not parked");

   // a finished sum reaches the output register when it is free
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not delivered");

endmodule

`default_nettype wire
